### design/ini_key_value_lookup_assert.svh
// Assertion macros for the INI key/value lookup block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INI_KEY_VALUE_LOOKUP_ASSERT_SVH
`define INI_KEY_VALUE_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low).
`define IKVL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ikvl check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted (active low).
`define IKVL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ikvl check failed (next cycle)");

`else

`define IKVL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define IKVL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### design/ikvl_pkg.sv
// Shared types, constants and helper functions for the INI key/value lookup.
// Used by every module of the block; depends on nothing else.
package ikvl_pkg;

    localparam int NAME_MAX_DEF  = 16;
    localparam int VALUE_MAX_DEF = 32;

    localparam int REG_W         = 64;
    localparam int LEN_W         = 5;
    localparam int NAME_CFG_BITS = 128;
    localparam int CFG_ADDR_W    = 6;
    localparam int REG_IDX_LSB   = 3;

    // Command and status widths cover the largest value store (64 entries).
    localparam int RD_ADDR_W = 6;
    localparam int EMIT_W    = 7;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {
        REG_SEC_LO  = 3'd0,
        REG_SEC_HI  = 3'd1,
        REG_SEC_LEN = 3'd2,
        REG_KEY_LO  = 3'd3,
        REG_KEY_HI  = 3'd4,
        REG_KEY_LEN = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_STRUCT_ERR = 3'd2,
        ST_BAD_SECT   = 3'd3,
        ST_BAD_KEY    = 3'd4,
        ST_BAD_VALUE  = 3'd5,
        ST_TOO_LONG   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        M_OUT   = 3'd0,
        M_SECT  = 3'd1,
        M_AFTER = 3'd2,
        M_KEY   = 3'd3,
        M_VAL   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [NAME_CFG_BITS-1:0] sec_name;
        logic [LEN_W-1:0]         sec_len;
        logic [NAME_CFG_BITS-1:0] key_name;
        logic [LEN_W-1:0]         key_len;
    } t_cfg;

    typedef struct packed {
        logic                 step;
        logic                 send;
        logic                 last;
        logic [RD_ADDR_W-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic              slot_free;
        logic              hit;
        logic [EMIT_W-1:0] emit_len;
    } t_stat;

    function automatic logic is_name_char(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                         CH_US, CH_DOT, CH_COLON};
    endfunction

endpackage

### design/ikvl_cfg_regs.sv
// APB-style configuration registers holding the wanted section and key names.
// Depends on ikvl_pkg.
module ikvl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ikvl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ikvl_pkg::REG_W-1:0]       pwdata,
    output logic [ikvl_pkg::REG_W-1:0]       prdata,
    output logic                             pready,
    output ikvl_pkg::t_cfg                   o_cfg
);

    logic [ikvl_pkg::REG_W-1:0] r_sec_lo, r_sec_hi, r_key_lo, r_key_hi;
    logic [ikvl_pkg::LEN_W-1:0] r_sec_len, r_key_len;
    ikvl_pkg::t_reg_idx         reg_idx;
    logic                       wr_en;

    assign reg_idx = ikvl_pkg::t_reg_idx'(paddr[ikvl_pkg::CFG_ADDR_W-1:ikvl_pkg::REG_IDX_LSB]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_lo  <= '0;
            r_sec_hi  <= '0;
            r_sec_len <= '0;
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                ikvl_pkg::REG_SEC_LO:  r_sec_lo  <= pwdata;
                ikvl_pkg::REG_SEC_HI:  r_sec_hi  <= pwdata;
                ikvl_pkg::REG_SEC_LEN: r_sec_len <= pwdata[ikvl_pkg::LEN_W-1:0];
                ikvl_pkg::REG_KEY_LO:  r_key_lo  <= pwdata;
                ikvl_pkg::REG_KEY_HI:  r_key_hi  <= pwdata;
                ikvl_pkg::REG_KEY_LEN: r_key_len <= pwdata[ikvl_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ikvl_pkg::REG_SEC_LO:  prdata = r_sec_lo;
            ikvl_pkg::REG_SEC_HI:  prdata = r_sec_hi;
            ikvl_pkg::REG_SEC_LEN: prdata = ikvl_pkg::REG_W'(r_sec_len);
            ikvl_pkg::REG_KEY_LO:  prdata = r_key_lo;
            ikvl_pkg::REG_KEY_HI:  prdata = r_key_hi;
            ikvl_pkg::REG_KEY_LEN: prdata = ikvl_pkg::REG_W'(r_key_len);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.sec_name = {r_sec_hi, r_sec_lo};
    assign o_cfg.sec_len  = r_sec_len;
    assign o_cfg.key_name = {r_key_hi, r_key_lo};
    assign o_cfg.key_len  = r_key_len;

endmodule

### design/ikvl_ctrl.sv
// Controller state machine: input acceptance and sequencing of a found value run.
// Depends on ikvl_pkg and ini_key_value_lookup_assert.svh.
`include "ini_key_value_lookup_assert.svh"

module ikvl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ikvl_pkg::t_stat i_stat,
    output ikvl_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_RUN  = 2'd0,
        S_READ = 2'd1,
        S_SEND = 2'd2
    } t_state;

    t_state                        r_state, n_state;
    logic [ikvl_pkg::EMIT_W-1:0]   r_idx, n_idx, idx_inc;

    assign idx_inc = r_idx + ikvl_pkg::EMIT_W'(1);

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.rd_addr = r_idx[ikvl_pkg::RD_ADDR_W-1:0];
        o_in_stall    = 1'b1;
        case (r_state)
            S_RUN: begin
                o_in_stall = !i_stat.slot_free;
                o_cmd.step = i_in_valid && i_stat.slot_free;
                if (o_cmd.step && i_stat.hit) begin
                    n_state = S_READ;
                    n_idx   = '0;
                end
            end
            // Wait state while the value store read lands in its output register.
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_stat.slot_free) begin
                    o_cmd.send = 1'b1;
                    o_cmd.last = (idx_inc == i_stat.emit_len);
                    if (o_cmd.last) begin
                        n_state = S_RUN;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    `IKVL_ASSERT_NXT(a_read_then_send, i_clk, i_rst_n, r_state == S_READ, r_state == S_SEND)
    `IKVL_ASSERT_IMP(a_idx_in_run, i_clk, i_rst_n, r_state != S_RUN, r_idx < i_stat.emit_len)
    `IKVL_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, o_cmd.send && o_cmd.last, r_state == S_RUN)
    `IKVL_ASSERT_NXT(a_hit_starts, i_clk, i_rst_n, o_cmd.step && i_stat.hit, r_state == S_READ && r_idx == 7'd0)

endmodule

### design/ikvl_datapath.sv
// Parser datapath: mode and counters, name and value stores, match logic, result register.
// Depends on ikvl_pkg; driven by commands from ikvl_ctrl.
module ikvl_datapath #(
    parameter int NAME_MAX  = ikvl_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = ikvl_pkg::VALUE_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ikvl_pkg::t_cfg  i_cfg,
    input  ikvl_pkg::t_cmd  i_cmd,
    output ikvl_pkg::t_stat o_stat,
    input  logic            i_op,
    input  logic [7:0]      i_data_byte,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_status,
    output logic [7:0]      o_value_byte,
    output logic [5:0]      o_value_length,
    output logic            o_last
);

    localparam int NCW = $clog2(NAME_MAX + 1);
    localparam int NIW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int VCW = $clog2(VALUE_MAX + 1);
    localparam int VIW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

    ikvl_pkg::t_mode   r_mode, n_mode;
    logic              r_skip, n_skip;
    logic              r_fin, n_fin;
    logic [NCW-1:0]    r_sec_cnt, n_sec_cnt, r_sec_len, n_sec_len;
    logic [NCW-1:0]    r_key_cnt, n_key_cnt, r_key_len, n_key_len;
    logic [VCW-1:0]    r_val_cnt, n_val_cnt, r_emit_len, n_emit_len;

    logic [7:0]        r_sec_store [NAME_MAX];
    logic [7:0]        r_key_store [NAME_MAX];
    logic [7:0]        r_val_mem   [VALUE_MAX];
    logic [7:0]        r_rd_data;

    logic              sec_we, key_we, val_we;
    logic [7:0]        val_wdata;
    logic              res_valid, hit;
    ikvl_pkg::t_status res_status;
    logic              sec_ok, key_ok;

    logic              r_out_valid;
    ikvl_pkg::t_status r_out_status;
    logic [7:0]        r_out_byte;
    logic [5:0]        r_out_len;
    logic              r_out_last;
    logic              slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    // Names compare against the latched lengths; entries past the length do not count.
    always_comb begin
        sec_ok = (i_cfg.sec_len == ikvl_pkg::LEN_W'(r_sec_len));
        key_ok = (i_cfg.key_len == ikvl_pkg::LEN_W'(r_key_len));
        for (int i = 0; i < NAME_MAX; i++) begin
            if (NCW'(i) < r_sec_len && r_sec_store[i] != i_cfg.sec_name[8*i +: 8]) begin
                sec_ok = 1'b0;
            end
            if (NCW'(i) < r_key_len && r_key_store[i] != i_cfg.key_name[8*i +: 8]) begin
                key_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_skip     = r_skip;
        n_fin      = r_fin;
        n_sec_cnt  = r_sec_cnt;
        n_sec_len  = r_sec_len;
        n_key_cnt  = r_key_cnt;
        n_key_len  = r_key_len;
        n_val_cnt  = r_val_cnt;
        n_emit_len = r_emit_len;
        sec_we     = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        val_wdata  = i_data_byte;
        res_valid  = 1'b0;
        res_status = ikvl_pkg::ST_NOT_FOUND;
        hit        = 1'b0;

        if (i_cmd.step) begin
            if (i_op) begin
                // End of file re-arms the parser; a finished file gives no second result.
                n_mode    = ikvl_pkg::M_OUT;
                n_skip    = 1'b0;
                n_fin     = 1'b0;
                n_sec_cnt = '0;
                n_sec_len = '0;
                n_key_cnt = '0;
                n_key_len = '0;
                n_val_cnt = '0;
                res_valid = !r_fin;
            end else if (!r_fin) begin
                if (i_data_byte == ikvl_pkg::CH_NL) begin
                    n_skip = 1'b0;
                end
                if (!r_skip || i_data_byte == ikvl_pkg::CH_NL) begin
                    case (i_data_byte)
                        ikvl_pkg::CH_HASH: begin
                            n_skip = 1'b1;
                        end
                        ikvl_pkg::CH_LBRACK: begin
                            n_mode = ikvl_pkg::M_SECT;
                        end
                        ikvl_pkg::CH_RBRACK: begin
                            if (r_mode != ikvl_pkg::M_SECT) begin
                                res_valid  = 1'b1;
                                res_status = ikvl_pkg::ST_STRUCT_ERR;
                            end else begin
                                n_sec_len = r_sec_cnt;
                                n_sec_cnt = '0;
                                n_mode    = ikvl_pkg::M_AFTER;
                            end
                        end
                        ikvl_pkg::CH_EQ: begin
                            if (r_mode != ikvl_pkg::M_KEY) begin
                                res_valid  = 1'b1;
                                res_status = ikvl_pkg::ST_STRUCT_ERR;
                            end else begin
                                n_key_len = r_key_cnt;
                                n_key_cnt = '0;
                                n_mode    = ikvl_pkg::M_VAL;
                            end
                        end
                        ikvl_pkg::CH_SPACE, ikvl_pkg::CH_TAB: begin
                            if (r_mode == ikvl_pkg::M_VAL && r_val_cnt != '0) begin
                                if (r_val_cnt >= VCW'(VALUE_MAX)) begin
                                    res_valid  = 1'b1;
                                    res_status = ikvl_pkg::ST_TOO_LONG;
                                end else begin
                                    val_we    = 1'b1;
                                    val_wdata = ikvl_pkg::CH_SPACE;
                                    n_val_cnt = r_val_cnt + VCW'(1);
                                end
                            end
                        end
                        default: begin
                            case (r_mode)
                                ikvl_pkg::M_SECT: begin
                                    if (!ikvl_pkg::is_name_char(i_data_byte)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_BAD_SECT;
                                    end else if (r_sec_cnt >= NCW'(NAME_MAX)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_TOO_LONG;
                                    end else begin
                                        sec_we    = 1'b1;
                                        n_sec_cnt = r_sec_cnt + NCW'(1);
                                    end
                                end
                                ikvl_pkg::M_AFTER: begin
                                    if (ikvl_pkg::is_name_char(i_data_byte)) begin
                                        if (r_key_cnt >= NCW'(NAME_MAX)) begin
                                            res_valid  = 1'b1;
                                            res_status = ikvl_pkg::ST_TOO_LONG;
                                        end else begin
                                            key_we    = 1'b1;
                                            n_key_cnt = r_key_cnt + NCW'(1);
                                            n_mode    = ikvl_pkg::M_KEY;
                                        end
                                    end else begin
                                        n_key_cnt = '0;
                                    end
                                end
                                ikvl_pkg::M_KEY: begin
                                    if (!ikvl_pkg::is_name_char(i_data_byte)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_BAD_KEY;
                                    end else if (r_key_cnt >= NCW'(NAME_MAX)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_TOO_LONG;
                                    end else begin
                                        key_we    = 1'b1;
                                        n_key_cnt = r_key_cnt + NCW'(1);
                                    end
                                end
                                ikvl_pkg::M_VAL: begin
                                    if (i_data_byte == ikvl_pkg::CH_NL) begin
                                        n_val_cnt = '0;
                                        n_mode    = ikvl_pkg::M_AFTER;
                                        if (sec_ok && key_ok) begin
                                            n_fin = 1'b1;
                                            if (r_val_cnt == '0) begin
                                                res_valid  = 1'b1;
                                                res_status = ikvl_pkg::ST_FOUND;
                                            end else begin
                                                hit        = 1'b1;
                                                n_emit_len = r_val_cnt;
                                            end
                                        end
                                    end else if (!ikvl_pkg::is_name_char(i_data_byte)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_BAD_VALUE;
                                    end else if (r_val_cnt >= VCW'(VALUE_MAX)) begin
                                        res_valid  = 1'b1;
                                        res_status = ikvl_pkg::ST_TOO_LONG;
                                    end else begin
                                        val_we    = 1'b1;
                                        n_val_cnt = r_val_cnt + VCW'(1);
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                    // Every result that a byte produces ends the file.
                    if (res_valid) begin
                        n_fin = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ikvl_pkg::M_OUT;
            r_skip     <= 1'b0;
            r_fin      <= 1'b0;
            r_sec_cnt  <= '0;
            r_sec_len  <= '0;
            r_key_cnt  <= '0;
            r_key_len  <= '0;
            r_val_cnt  <= '0;
            r_emit_len <= '0;
        end else begin
            r_mode     <= n_mode;
            r_skip     <= n_skip;
            r_fin      <= n_fin;
            r_sec_cnt  <= n_sec_cnt;
            r_sec_len  <= n_sec_len;
            r_key_cnt  <= n_key_cnt;
            r_key_len  <= n_key_len;
            r_val_cnt  <= n_val_cnt;
            r_emit_len <= n_emit_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sec_we) begin
            r_sec_store[r_sec_cnt[NIW-1:0]] <= i_data_byte;
        end
        if (key_we) begin
            r_key_store[r_key_cnt[NIW-1:0]] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[r_val_cnt[VIW-1:0]] <= val_wdata;
        end
        r_rd_data <= r_val_mem[i_cmd.rd_addr[VIW-1:0]];
    end

    // Result register: loaded by a status transaction or by one byte of a value run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.step && res_valid) || i_cmd.send) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_out_status <= ikvl_pkg::ST_FOUND;
            r_out_byte   <= r_rd_data;
            r_out_len    <= 6'(r_emit_len);
            r_out_last   <= i_cmd.last;
        end else if (i_cmd.step && res_valid) begin
            r_out_status <= res_status;
            r_out_byte   <= 8'd0;
            r_out_len    <= 6'd0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value_byte   = r_out_byte;
    assign o_value_length = r_out_len;
    assign o_last         = r_out_last;

    assign o_stat.slot_free = slot_free;
    assign o_stat.hit       = hit;
    assign o_stat.emit_len  = ikvl_pkg::EMIT_W'(r_emit_len);

endmodule

### design/ini_key_value_lookup.sv
// INI key/value lookup. The block takes one file byte (or an end-of-file marker)
// per transaction and accepts a new byte every cycle while parsing and not
// stalled; a status result (error, not found, or an empty value found) is loaded
// into the output register in the cycle its byte is accepted. When the configured
// section and key match, the value of n bytes is sent as a run of n transactions,
// the last one flagged; each byte is first read from the value store into its
// read register, then loaded into the output register once it is free. Input is
// stalled during the run and while the output register is full and stalled.
// Bytes after a final result are accepted and ignored until end of file.
// Depends on ikvl_pkg, ikvl_cfg_regs, ikvl_ctrl and ikvl_datapath.
module ini_key_value_lookup #(
    parameter int NAME_MAX  = ikvl_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = ikvl_pkg::VALUE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ikvl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ikvl_pkg::REG_W-1:0]      pwdata,
    output logic [ikvl_pkg::REG_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic [7:0]                      o_value_byte,
    output logic [5:0]                      o_value_length,
    output logic                            o_last
);

    ikvl_pkg::t_cfg  cfg;
    ikvl_pkg::t_cmd  cmd;
    ikvl_pkg::t_stat stat;

    ikvl_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ikvl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ikvl_datapath #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_value_byte   (o_value_byte),
        .o_value_length (o_value_length),
        .o_last         (o_last)
    );

endmodule
